FILE: rtl/core/ssu_pkg.sv
// Shared types and constants of the stack shuffle unit.
// Shuffle operation codes, status codes, cell control word, need/grow tables.
// No dependencies.
package ssu_pkg;

   typedef enum logic [4:0] {
      OP_PUSH     = 5'd0,
      OP_DROP     = 5'd1,
      OP_2DROP    = 5'd2,
      OP_3DROP    = 5'd3,
      OP_DUP      = 5'd4,
      OP_2DUP     = 5'd5,
      OP_3DUP     = 5'd6,
      OP_ROT      = 5'd7,
      OP_NROT     = 5'd8,
      OP_DUPD     = 5'd9,
      OP_SWAPD    = 5'd10,
      OP_NIP      = 5'd11,
      OP_2NIP     = 5'd12,
      OP_TUCK     = 5'd13,
      OP_OVER     = 5'd14,
      OP_PICK     = 5'd15,
      OP_SWAP     = 5'd16,
      OP_TO_RET   = 5'd17,
      OP_FROM_RET = 5'd18,
      OP_RESET    = 5'd19
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   // Cell source select: codes 0..6 take the neighbor at offset (code - 3),
   // i.e. new[i] = old[i + code - 3]; SRC_EXT takes the external value.
   localparam logic [2:0] SRC_DN1  = 3'd2;
   localparam logic [2:0] SRC_KEEP = 3'd3;
   localparam logic [2:0] SRC_UP1  = 3'd4;
   localparam logic [2:0] SRC_EXT  = 3'd7;

   typedef struct packed {
      logic       load;
      logic [2:0] src;
   } shift_type;

   // cells an operation needs on the data stack
   function automatic logic [1:0] mode_need(input mode_type op);
      logic [1:0] n;
      case (op)
         OP_DROP, OP_DUP, OP_TO_RET:                     n = 2'd1;
         OP_2DROP, OP_2DUP, OP_DUPD, OP_NIP, OP_TUCK,
         OP_OVER, OP_SWAP:                               n = 2'd2;
         OP_3DROP, OP_3DUP, OP_ROT, OP_NROT, OP_SWAPD,
         OP_2NIP, OP_PICK:                               n = 2'd3;
         default:                                        n = 2'd0;
      endcase
      return n;
   endfunction

   // net change of the data depth
   function automatic logic signed [2:0] mode_grow(input mode_type op);
      logic signed [2:0] g;
      case (op)
         OP_PUSH, OP_DUP, OP_DUPD, OP_TUCK, OP_OVER,
         OP_PICK, OP_FROM_RET:                           g = 3'sd1;
         OP_2DUP:                                        g = 3'sd2;
         OP_3DUP:                                        g = 3'sd3;
         OP_DROP, OP_NIP, OP_TO_RET:                     g = -3'sd1;
         OP_2DROP, OP_2NIP:                              g = -3'sd2;
         OP_3DROP:                                       g = -3'sd3;
         default:                                        g = 3'sd0;
      endcase
      return g;
   endfunction

endpackage

FILE: rtl/core/ssu_cell.sv
// One stack cell of the shift chain.
// Uses ssu_pkg (shift_type, source codes).
module ssu_cell #(
   parameter int W = 64
) (
   input  logic                  clock,
   input  ssu_pkg::shift_type    ctl,
   input  logic [6:0][W-1:0]     nbr,   // nbr[j] = old cell at offset j-3
   input  logic [W-1:0]          ext,
   output logic [W-1:0]          dout
);

   logic [W-1:0] cell_ff;
   logic [W-1:0] cell_in;

   always_comb begin
      if (ctl.src == ssu_pkg::SRC_EXT) begin
         cell_in = ext;
      end else begin
         cell_in = nbr[ctl.src];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cell_ff <= cell_in;
      end
   end

   assign dout = cell_ff;

endmodule

FILE: rtl/core/ssu_ctrl.sv
// Operation decoder: bounds checks, next depths, new top cells, chain controls.
// Uses ssu_pkg (codes, tables, shift_type).
module ssu_ctrl #(
   parameter int DATA_DEPTH   = 32,
   parameter int RETAIN_DEPTH = 32,
   parameter int CELL_BITS    = 64,
   parameter int DC_W         = 6,
   parameter int RC_W         = 6
) (
   input  logic                      go,
   input  logic [4:0]                mode,
   input  logic [CELL_BITS-1:0]      value,
   input  logic [DC_W-1:0]           d,
   input  logic [RC_W-1:0]           r,
   input  logic [5:0][CELL_BITS-1:0] o,       // old data cells, top first
   input  logic [CELL_BITS-1:0]      r0,
   input  logic [CELL_BITS-1:0]      r1,
   output ssu_pkg::status_type       status,
   output logic [DC_W-1:0]           d_nxt,
   output logic [RC_W-1:0]           r_nxt,
   output logic [2:0][CELL_BITS-1:0] ext,     // new top three data cells
   output logic [2:0][CELL_BITS-1:0] new_top, // top three after this word
   output logic [CELL_BITS-1:0]      new_rtop,
   output ssu_pkg::shift_type        data_top_ctl,
   output ssu_pkg::shift_type        data_rest_ctl,
   output ssu_pkg::shift_type        ret_top_ctl,
   output ssu_pkg::shift_type        ret_rest_ctl
);

   ssu_pkg::mode_type op;
   logic [1:0]        need;
   logic signed [2:0] g;
   logic              op_valid;
   logic              change;
   logic              ret_op;
   logic [DC_W:0]     d_sum;
   logic [2:0]        src_sh;

   assign op       = ssu_pkg::mode_type'(mode);
   assign need     = ssu_pkg::mode_need(op);
   assign g        = ssu_pkg::mode_grow(op);
   assign op_valid = (op <= ssu_pkg::OP_FROM_RET);
   assign d_sum    = (DC_W + 1)'(d) + (DC_W + 1)'(g[2] ? 2'd0 : g[1:0]);
   assign src_sh   = ssu_pkg::SRC_KEEP - 3'(g);
   assign ret_op   = (op == ssu_pkg::OP_TO_RET) || (op == ssu_pkg::OP_FROM_RET);

   // underflow wins over overflow
   always_comb begin
      status = ssu_pkg::ST_OK;
      if (op_valid) begin
         if ((d < DC_W'(need)) || ((op == ssu_pkg::OP_FROM_RET) && (r == '0))) begin
            status = ssu_pkg::ST_UNDER;
         end else if ((!g[2] && (d_sum > (DC_W + 1)'(DATA_DEPTH))) ||
                      ((op == ssu_pkg::OP_TO_RET) && (r >= RC_W'(RETAIN_DEPTH)))) begin
            status = ssu_pkg::ST_OVER;
         end
      end
   end

   assign change = go && op_valid && (status == ssu_pkg::ST_OK);

   // new top three, top first
   always_comb begin
      case (g)
         -3'sd1:  ext = {o[3], o[2], o[1]};
         -3'sd2:  ext = {o[4], o[3], o[2]};
         -3'sd3:  ext = {o[5], o[4], o[3]};
         default: ext = {o[2], o[1], o[0]};
      endcase
      case (op)
         ssu_pkg::OP_PUSH:     ext = {o[1], o[0], value};
         ssu_pkg::OP_DUP:      ext = {o[1], o[0], o[0]};
         ssu_pkg::OP_2DUP:     ext = {o[0], o[1], o[0]};
         ssu_pkg::OP_3DUP:     ext = {o[2], o[1], o[0]};
         ssu_pkg::OP_ROT:      ext = {o[1], o[0], o[2]};
         ssu_pkg::OP_NROT:     ext = {o[0], o[2], o[1]};
         ssu_pkg::OP_DUPD:     ext = {o[1], o[1], o[0]};
         ssu_pkg::OP_SWAPD:    ext = {o[1], o[2], o[0]};
         ssu_pkg::OP_NIP:      ext = {o[3], o[2], o[0]};
         ssu_pkg::OP_2NIP:     ext = {o[4], o[3], o[0]};
         ssu_pkg::OP_TUCK:     ext = {o[0], o[1], o[0]};
         ssu_pkg::OP_OVER:     ext = {o[1], o[0], o[1]};
         ssu_pkg::OP_PICK:     ext = {o[1], o[0], o[2]};
         ssu_pkg::OP_SWAP:     ext = {o[2], o[0], o[1]};
         ssu_pkg::OP_FROM_RET: ext = {o[1], o[0], r0};
         default: ;
      endcase
   end

   always_comb begin
      new_top  = change ? ext : {o[2], o[1], o[0]};
      new_rtop = r0;
      if (change && (op == ssu_pkg::OP_TO_RET)) begin
         new_rtop = o[0];
      end else if (change && (op == ssu_pkg::OP_FROM_RET)) begin
         new_rtop = r1;
      end
   end

   always_comb begin
      d_nxt = d;
      r_nxt = r;
      if (go && (op == ssu_pkg::OP_RESET)) begin
         d_nxt = '0;
         r_nxt = '0;
      end else if (change) begin
         d_nxt = d + DC_W'(g);
         if (op == ssu_pkg::OP_TO_RET) begin
            r_nxt = r + RC_W'(1);
         end else if (op == ssu_pkg::OP_FROM_RET) begin
            r_nxt = r - RC_W'(1);
         end
      end
   end

   assign data_top_ctl  = '{load: change, src: ssu_pkg::SRC_EXT};
   assign data_rest_ctl = '{load: change, src: src_sh};
   assign ret_top_ctl   = '{load: change && ret_op,
                            src: (op == ssu_pkg::OP_TO_RET) ? ssu_pkg::SRC_EXT
                                                            : ssu_pkg::SRC_UP1};
   assign ret_rest_ctl  = '{load: change && ret_op,
                            src: (op == ssu_pkg::OP_TO_RET) ? ssu_pkg::SRC_DN1
                                                            : ssu_pkg::SRC_UP1};

endmodule

FILE: rtl/core/stack_shuffle_unit_top.sv
// Top level of the stack shuffle unit: data and retain stacks as cell chains.
// Uses ssu_pkg, ssu_cell, ssu_ctrl.
//
// Usage:
//  - Request channel (req_*): one word per shuffle operation. req_tuser holds
//    the operation code, req_tdata the cell pushed by a push.
//  - Response channel (rsp_*): exactly one word per request, in order. It
//    shows the top three data cells, the retain top (zero where absent),
//    both depths, and a status in rsp_tuser (ok, underflow, overflow).
//    On underflow or overflow neither stack changes.
//  - Output: registered; valid in the cycle after the request is taken.
//  - Throughput: one word per cycle while responses are taken. Every operation
//    moves each stack cell at most three places along its chain, and all
//    cells of the chain load together when an operation is applied.
//  - Stall: the response sits in an output register. While it waits and
//    rsp_tready is low, req_tready is low; when it is taken, a new request
//    is taken in the same cycle.
//  - Reset: both depths go to zero and the output register empties. Cell
//    contents are not cleared; cells above the depth are never shown.
module stack_shuffle_unit_top #(
   parameter int DATA_DEPTH   = 32,   // 4..1024
   parameter int RETAIN_DEPTH = 32,   // 2..1024
   parameter int CELL_BITS    = 64,   // 8..64
   localparam int DC_W  = $clog2(DATA_DEPTH + 1),
   localparam int RC_W  = $clog2(RETAIN_DEPTH + 1),
   localparam int REQ_W = ((CELL_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((4 * CELL_BITS + DC_W + RC_W + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_W-1:0]    req_tdata,   // value
   input  logic [4:0]          req_tuser,   // mode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // top_cell, second_cell, third_cell, retain_top, data_count, retain_count
   output logic [RSP_W-1:0]    rsp_tdata,
   output logic [1:0]          rsp_tuser    // status
);

   logic accept;

   // depth registers
   logic [DC_W-1:0] dcnt_ff, dcnt_in;
   logic [RC_W-1:0] rcnt_ff, rcnt_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff;
   ssu_pkg::status_type rsp_status_ff;

   // cell chains, padded with three zero cells on each end
   logic [DATA_DEPTH+5:0][CELL_BITS-1:0]   dpad;
   logic [RETAIN_DEPTH+5:0][CELL_BITS-1:0] rpad;
   logic [CELL_BITS-1:0] dcell [DATA_DEPTH];
   logic [CELL_BITS-1:0] rcell [RETAIN_DEPTH];

   // decoder outputs
   ssu_pkg::status_type       status;
   logic [2:0][CELL_BITS-1:0] ext;
   logic [2:0][CELL_BITS-1:0] new_top;
   logic [CELL_BITS-1:0]      new_rtop;
   ssu_pkg::shift_type        data_top_ctl, data_rest_ctl;
   ssu_pkg::shift_type        ret_top_ctl, ret_rest_ctl;

   // shown values, zero where absent
   logic [CELL_BITS-1:0] show_top, show_second, show_third, show_rtop;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      dpad = '0;
      for (int k = 0; k < DATA_DEPTH; k++) begin
         dpad[k + 3] = dcell[k];
      end
      rpad = '0;
      for (int k = 0; k < RETAIN_DEPTH; k++) begin
         rpad[k + 3] = rcell[k];
      end
   end

   ssu_ctrl #(
      .DATA_DEPTH   (DATA_DEPTH),
      .RETAIN_DEPTH (RETAIN_DEPTH),
      .CELL_BITS    (CELL_BITS),
      .DC_W         (DC_W),
      .RC_W         (RC_W)
   ) u_ctrl (
      .go            (accept),
      .mode          (req_tuser),
      .value         (req_tdata[CELL_BITS-1:0]),
      .d             (dcnt_ff),
      .r             (rcnt_ff),
      .o             (dpad[8:3]),
      .r0            (rpad[3]),
      .r1            (rpad[4]),
      .status        (status),
      .d_nxt         (dcnt_in),
      .r_nxt         (rcnt_in),
      .ext           (ext),
      .new_top       (new_top),
      .new_rtop      (new_rtop),
      .data_top_ctl  (data_top_ctl),
      .data_rest_ctl (data_rest_ctl),
      .ret_top_ctl   (ret_top_ctl),
      .ret_rest_ctl  (ret_rest_ctl)
   );

   // data stack: cell 0 is the top; top three take the shuffled values
   for (genvar i = 0; i < DATA_DEPTH; i++) begin : g_data
      if (i < 3) begin : g_head
         ssu_cell #(.W(CELL_BITS)) u_cell (
            .clock (clock),
            .ctl   (data_top_ctl),
            .nbr   (dpad[i+6:i]),
            .ext   (ext[i]),
            .dout  (dcell[i])
         );
      end else begin : g_body
         ssu_cell #(.W(CELL_BITS)) u_cell (
            .clock (clock),
            .ctl   (data_rest_ctl),
            .nbr   (dpad[i+6:i]),
            .ext   ('0),
            .dout  (dcell[i])
         );
      end
   end

   // retain stack: cell 0 is the top and takes the data top on a move
   for (genvar i = 0; i < RETAIN_DEPTH; i++) begin : g_ret
      if (i == 0) begin : g_head
         ssu_cell #(.W(CELL_BITS)) u_cell (
            .clock (clock),
            .ctl   (ret_top_ctl),
            .nbr   (rpad[i+6:i]),
            .ext   (dpad[3]),
            .dout  (rcell[i])
         );
      end else begin : g_body
         ssu_cell #(.W(CELL_BITS)) u_cell (
            .clock (clock),
            .ctl   (ret_rest_ctl),
            .nbr   (rpad[i+6:i]),
            .ext   ('0),
            .dout  (rcell[i])
         );
      end
   end

   assign show_top    = (dcnt_in != '0)         ? new_top[0] : '0;
   assign show_second = (dcnt_in >= DC_W'(2))   ? new_top[1] : '0;
   assign show_third  = (dcnt_in >= DC_W'(3))   ? new_top[2] : '0;
   assign show_rtop   = (rcnt_in != '0)         ? new_rtop   : '0;

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff      <= '0;
         rcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dcnt_ff      <= dcnt_in;
         rcnt_ff      <= rcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= RSP_W'({rcnt_in, dcnt_in, show_rtop, show_third,
                                  show_second, show_top});
         rsp_status_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // a rejected operation leaves both depths alone
   a_err_keeps_depth : assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_status_ff == ssu_pkg::ST_OK) ||
                 ((dcnt_ff == $past(dcnt_ff)) && (rcnt_ff == $past(rcnt_ff))))
      else $error("depth changed on a rejected operation");

   a_reset_op : assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == ssu_pkg::OP_RESET) |=>
         (rsp_status_ff == ssu_pkg::ST_OK) && (dcnt_ff == '0) && (rcnt_ff == '0))
      else $error("stack reset operation did not empty both stacks");

   a_depth_bound : assert property (@(posedge clock) disable iff (reset)
      (dcnt_ff <= DC_W'(DATA_DEPTH)) && (rcnt_ff <= RC_W'(RETAIN_DEPTH)))
      else $error("stack depth beyond capacity");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !accept)
      else $error("request taken while response stalled");

endmodule

FILE: test/tb_top.sv
// Testbench for stack_shuffle_unit_top: random and directed shuffle words,
// with a mirror of both stacks that checks every response word field by field.
// Depends on ssu_pkg and the stack shuffle unit RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int DATA_CELLS_MAX   = 32;
   localparam int RETAIN_CELLS_MAX = 32;
   localparam int CELL_W           = 64;
   localparam int REQ_BITS         = 64;    // value
   localparam int RSP_BITS         = 272;   // 4 cells + 2 counts, padded to bytes
   localparam int CYCLE_LIMIT      = 200000;
   localparam int WORDS_PER_PHASE  = 206;
   localparam int BIAS_SPAN        = 64;    // words between changes of op mix

   // op mixes that steer the stacks toward their corners
   typedef enum int {
      BIAS_MIX,
      BIAS_FILL,     // data stack toward full
      BIAS_RETAIN,   // retain stack toward full
      BIAS_DRAIN,    // data stack toward empty, retain growing
      BIAS_EMPTY     // both toward empty
   } shuffle_bias_type;

   // one response word, unpacked
   typedef struct {
      logic [CELL_W-1:0]   top_cell;
      logic [CELL_W-1:0]   second_cell;
      logic [CELL_W-1:0]   third_cell;
      logic [CELL_W-1:0]   retain_top;
      logic [5:0]          data_count;
      logic [5:0]          retain_count;
      ssu_pkg::status_type status;
   } stack_view_type;

   // Mirror of both stacks; predicts the view after every accepted shuffle.
   class stack_mirror;
      logic [CELL_W-1:0] data_cells [DATA_CELLS_MAX];
      logic [CELL_W-1:0] retain_cells [RETAIN_CELLS_MAX];
      int                data_depth   = 0;
      int                retain_depth = 0;
      stack_view_type    views_due [$];
      int                fail_count   = 0;

      function logic [CELL_W-1:0] peek(input int k);
         return (k < data_depth) ? data_cells[data_depth - 1 - k] : '0;
      endfunction

      // apply one accepted shuffle and queue the view it should produce
      function void note_op(input logic [4:0] op, input logic [CELL_W-1:0] value);
         int                  need;
         int                  grow;
         int                  d;
         logic [CELL_W-1:0]   a, b, c;
         ssu_pkg::status_type st;
         stack_view_type      v;
         d    = data_depth;
         st   = ssu_pkg::ST_OK;
         need = 0;
         grow = 0;
         case (ssu_pkg::mode_type'(op))
            ssu_pkg::OP_PUSH:     begin need = 0; grow =  1; end
            ssu_pkg::OP_DROP:     begin need = 1; grow = -1; end
            ssu_pkg::OP_2DROP:    begin need = 2; grow = -2; end
            ssu_pkg::OP_3DROP:    begin need = 3; grow = -3; end
            ssu_pkg::OP_DUP:      begin need = 1; grow =  1; end
            ssu_pkg::OP_2DUP:     begin need = 2; grow =  2; end
            ssu_pkg::OP_3DUP:     begin need = 3; grow =  3; end
            ssu_pkg::OP_ROT:      begin need = 3; grow =  0; end
            ssu_pkg::OP_NROT:     begin need = 3; grow =  0; end
            ssu_pkg::OP_DUPD:     begin need = 2; grow =  1; end
            ssu_pkg::OP_SWAPD:    begin need = 3; grow =  0; end
            ssu_pkg::OP_NIP:      begin need = 2; grow = -1; end
            ssu_pkg::OP_2NIP:     begin need = 3; grow = -2; end
            ssu_pkg::OP_TUCK:     begin need = 2; grow =  1; end
            ssu_pkg::OP_OVER:     begin need = 2; grow =  1; end
            ssu_pkg::OP_PICK:     begin need = 3; grow =  1; end
            ssu_pkg::OP_SWAP:     begin need = 2; grow =  0; end
            ssu_pkg::OP_TO_RET:   begin need = 1; grow = -1; end
            ssu_pkg::OP_FROM_RET: begin need = 0; grow =  1; end
            default:              begin need = 0; grow =  0; end
         endcase

         if (op == ssu_pkg::OP_RESET) begin
            data_depth   = 0;
            retain_depth = 0;
         end else if (op <= ssu_pkg::OP_FROM_RET) begin
            // too few cells wins over too little room
            if (d < need || (op == ssu_pkg::OP_FROM_RET && retain_depth == 0))
               st = ssu_pkg::ST_UNDER;
            else if (d + grow > DATA_CELLS_MAX ||
                     (op == ssu_pkg::OP_TO_RET && retain_depth >= RETAIN_CELLS_MAX))
               st = ssu_pkg::ST_OVER;
            else begin
               a = peek(0);
               b = peek(1);
               c = peek(2);
               case (ssu_pkg::mode_type'(op))
                  ssu_pkg::OP_PUSH:  data_cells[d] = value;
                  ssu_pkg::OP_DUP:   data_cells[d] = a;
                  ssu_pkg::OP_2DUP: begin
                     data_cells[d] = b; data_cells[d+1] = a;
                  end
                  ssu_pkg::OP_3DUP: begin
                     data_cells[d] = c; data_cells[d+1] = b; data_cells[d+2] = a;
                  end
                  ssu_pkg::OP_ROT: begin
                     data_cells[d-3] = b; data_cells[d-2] = a; data_cells[d-1] = c;
                  end
                  ssu_pkg::OP_NROT: begin
                     data_cells[d-3] = a; data_cells[d-2] = c; data_cells[d-1] = b;
                  end
                  ssu_pkg::OP_DUPD: begin
                     data_cells[d-1] = b; data_cells[d] = a;
                  end
                  ssu_pkg::OP_SWAPD: begin
                     data_cells[d-3] = b; data_cells[d-2] = c;
                  end
                  ssu_pkg::OP_NIP:   data_cells[d-2] = a;
                  ssu_pkg::OP_2NIP:  data_cells[d-3] = a;
                  ssu_pkg::OP_TUCK: begin
                     data_cells[d-2] = a; data_cells[d-1] = b; data_cells[d] = a;
                  end
                  ssu_pkg::OP_OVER:  data_cells[d] = b;
                  ssu_pkg::OP_PICK:  data_cells[d] = c;
                  ssu_pkg::OP_SWAP: begin
                     data_cells[d-2] = a; data_cells[d-1] = b;
                  end
                  ssu_pkg::OP_TO_RET: begin
                     retain_cells[retain_depth] = a;
                     retain_depth++;
                  end
                  ssu_pkg::OP_FROM_RET: begin
                     retain_depth--;
                     data_cells[d] = retain_cells[retain_depth];
                  end
                  default: ;   // drops only move the depth
               endcase
               data_depth = d + grow;
            end
         end
         // codes 20..31 fall through: no change, status ok

         v.top_cell     = peek(0);
         v.second_cell  = peek(1);
         v.third_cell   = peek(2);
         v.retain_top   = (retain_depth > 0) ? retain_cells[retain_depth - 1] : '0;
         v.data_count   = 6'(data_depth);
         v.retain_count = 6'(retain_depth);
         v.status       = st;
         views_due.push_back(v);
      endfunction

      function void compare_field(input string name, input logic [CELL_W-1:0] want,
                                  input logic [CELL_W-1:0] seen);
         if (seen !== want) begin
            $error("%s: expected %h, got %h", name, want, seen);
            fail_count++;
         end
      endfunction

      function void check_view(input stack_view_type got);
         stack_view_type want;
         if (views_due.size() == 0) begin
            $error("response word with no request outstanding");
            fail_count++;
            return;
         end
         want = views_due.pop_front();
         compare_field("top_cell",     want.top_cell,     got.top_cell);
         compare_field("second_cell",  want.second_cell,  got.second_cell);
         compare_field("third_cell",   want.third_cell,   got.third_cell);
         compare_field("retain_top",   want.retain_top,   got.retain_top);
         compare_field("data_count",   64'(want.data_count),   64'(got.data_count));
         compare_field("retain_count", 64'(want.retain_count), 64'(got.retain_count));
         compare_field("status",       64'(want.status),       64'(got.status));
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset, DUT
   // ---------------------------------------------------------------------
   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata  = '0;    // value
   logic [4:0]          req_tuser  = '0;    // mode
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // top_cell, second_cell, third_cell, retain_top, data_count, retain_count
   logic [RSP_BITS-1:0] rsp_tdata;
   logic [1:0]          rsp_tuser;          // status

   int send_gap_pct    = 0;   // chance per cycle that the sender holds off
   int ready_stall_pct = 0;   // chance per cycle that the receiver stalls
   int cycle_count     = 0;

   stack_mirror shuffle_model = new();

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // reset once, synchronous to the clock
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   stack_shuffle_unit_top #(
      .DATA_DEPTH   (DATA_CELLS_MAX),
      .RETAIN_DEPTH (RETAIN_CELLS_MAX),
      .CELL_BITS    (CELL_W)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ---------------------------------------------------------------------
   // Receiver: random backpressure at the rate of the current phase
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Monitor: all sampling happens on the edge, before any NBA lands,
   // so both channels are seen with their pre-edge values.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      stack_view_type seen;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen.top_cell     = rsp_tdata[63:0];
            seen.second_cell  = rsp_tdata[127:64];
            seen.third_cell   = rsp_tdata[191:128];
            seen.retain_top   = rsp_tdata[255:192];
            seen.data_count   = rsp_tdata[261:256];
            seen.retain_count = rsp_tdata[267:262];
            seen.status       = ssu_pkg::status_type'(rsp_tuser);
            shuffle_model.check_view(seen);
         end
         if (req_tvalid && req_tready)
            shuffle_model.note_op(req_tuser, req_tdata);
      end
   end

   // watchdog: a hung handshake ends the run as a failure
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("stack_shuffle_unit_top verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------

   // Offer one shuffle word and hold it until taken. tvalid stays high
   // across back-to-back words; it only drops for a random hold-off or a drain.
   task automatic send_op(input logic [4:0] op, input logic [CELL_W-1:0] word_value);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word_value;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait for every outstanding response word. The first
   // edge makes sure the last accepted word has been noted by the monitor.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (shuffle_model.views_due.size() != 0);
   endtask

   function automatic logic [CELL_W-1:0] random_cell();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic logic [4:0] pick_drop();
      case ($urandom_range(0, 4))
         0:       return ssu_pkg::OP_DROP;
         1:       return ssu_pkg::OP_2DROP;
         2:       return ssu_pkg::OP_3DROP;
         3:       return ssu_pkg::OP_NIP;
         default: return ssu_pkg::OP_2NIP;
      endcase
   endfunction

   // Mostly legal shuffles weighted by the current mix, with a thin
   // sprinkle of stack resets and unused codes (which must be no-ops).
   function automatic logic [4:0] pick_op(input shuffle_bias_type bias);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 1)
         return ssu_pkg::OP_RESET;
      if (roll < 3)
         return 5'($urandom_range(20, 31));
      roll = $urandom_range(0, 99);
      case (bias)
         BIAS_FILL: begin
            if (roll < 50) return ssu_pkg::OP_PUSH;
            if (roll < 80) return 5'($urandom_range(ssu_pkg::OP_DUP, ssu_pkg::OP_PICK));
            if (roll < 85) return ssu_pkg::OP_FROM_RET;
         end
         BIAS_RETAIN: begin
            if (roll < 40) return ssu_pkg::OP_PUSH;
            if (roll < 80) return ssu_pkg::OP_TO_RET;
         end
         BIAS_DRAIN: begin
            if (roll < 60) return pick_drop();
            if (roll < 90) return ssu_pkg::OP_TO_RET;
         end
         BIAS_EMPTY: begin
            if (roll < 40) return ssu_pkg::OP_FROM_RET;
            if (roll < 80) return pick_drop();
         end
         default: ;
      endcase
      return 5'($urandom_range(ssu_pkg::OP_PUSH, ssu_pkg::OP_FROM_RET));
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int               gap_by_phase [4];
      int               stall_by_phase [4];
      shuffle_bias_type bias;
      gap_by_phase   = '{0, 71, 0, 12};
      stall_by_phase = '{0, 0, 71, 12};
      bias           = BIAS_MIX;

      while (reset) @(posedge clock);

      // Directed: errors on empty stacks, extreme cells, then every
      // shuffle at least once on a stack deep enough for it, ending in a reset.
      send_op(ssu_pkg::OP_FROM_RET, random_cell());    // retain empty
      send_op(ssu_pkg::OP_DROP,     random_cell());    // data empty
      send_op(ssu_pkg::OP_TO_RET,   random_cell());    // data empty
      send_op(ssu_pkg::OP_PUSH,     '0);
      send_op(ssu_pkg::OP_PUSH,     '1);
      send_op(ssu_pkg::OP_PUSH,     64'h0123_4567_89AB_CDEF);
      send_op(ssu_pkg::OP_DUP,      random_cell());
      send_op(ssu_pkg::OP_2DUP,     random_cell());
      send_op(ssu_pkg::OP_3DUP,     random_cell());
      send_op(ssu_pkg::OP_ROT,      random_cell());
      send_op(ssu_pkg::OP_NROT,     random_cell());
      send_op(ssu_pkg::OP_DUPD,     random_cell());
      send_op(ssu_pkg::OP_SWAPD,    random_cell());
      send_op(ssu_pkg::OP_NIP,      random_cell());
      send_op(ssu_pkg::OP_2NIP,     random_cell());
      send_op(ssu_pkg::OP_TUCK,     random_cell());
      send_op(ssu_pkg::OP_OVER,     random_cell());
      send_op(ssu_pkg::OP_PICK,     random_cell());
      send_op(ssu_pkg::OP_SWAP,     random_cell());
      send_op(ssu_pkg::OP_TO_RET,   random_cell());
      send_op(ssu_pkg::OP_FROM_RET, random_cell());
      send_op(ssu_pkg::OP_TO_RET,   random_cell());
      send_op(ssu_pkg::OP_DROP,     random_cell());
      send_op(ssu_pkg::OP_2DROP,    random_cell());
      send_op(ssu_pkg::OP_3DROP,    random_cell());
      send_op(5'd31,                random_cell());    // unused code
      send_op(ssu_pkg::OP_RESET,    random_cell());

      // sender holds off until the pipe is empty
      wait_drained();

      // Random: two passes over the four gap and stall phases; the op mix is redrawn
      // every BIAS_SPAN words so both stacks hit full and empty.
      for (int round = 0; round < 2; round++) begin
         for (int phase = 0; phase < 4; phase++) begin
            send_gap_pct    = gap_by_phase[phase];
            ready_stall_pct = stall_by_phase[phase];
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
               if (n % BIAS_SPAN == 0)
                  bias = shuffle_bias_type'($urandom_range(BIAS_MIX, BIAS_EMPTY));
               send_op(pick_op(bias), random_cell());
            end
            wait_drained();
         end
      end

      // spare edges catch any stray response word
      repeat (4) @(posedge clock);

      if (shuffle_model.fail_count == 0 && shuffle_model.views_due.size() == 0)
         $display("stack_shuffle_unit_top verification clean");
      else
         $display("stack_shuffle_unit_top verification failed");
      $finish;
   end

endmodule
